// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

    // Request codes.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_PARSE    = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_COPY    = 2'd1;

    localparam logic [7:0]  START_BYTE    = 8'hFD;
    localparam logic [7:0]  CR_BYTE       = 8'h0D;
    localparam logic [7:0]  LF_BYTE       = 8'h0A;
    localparam logic [6:0]  MIN_FRAME     = 7'd4;
    localparam logic [6:0]  MAX_RUN       = 7'd64;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;
    localparam logic [6:0]  COPY_RESET    = 7'd32;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [31:0] attempts;
        logic [31:0] received;
        logic [31:0] failed;
        logic [31:0] checksum_error;
        logic [31:0] timeout;
        logic [31:0] parse_error;
    } counters_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_byte;
        logic        last;
        logic [6:0]  frame_length;
        logic [31:0] attempts_count;
        logic [31:0] received_count;
        logic [31:0] failed_count;
        logic [31:0] checksum_error_count;
        logic [31:0] timeout_count;
        logic [31:0] parse_error_count;
    } rsp_t;

    // One unit of work handed from the front end to the drain side.
    typedef struct packed {
        logic [1:0] status;
        logic [6:0] frame_length;
        logic [6:0] run_length;
        counters_t  counters;
    } job_t;

endpackage

// ===== rtl/core/sfr_front.sv =====
module sfr_front #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  sfr_pkg::req_t                 req,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    output logic                          job_valid,
    input  logic                          job_ready,
    output sfr_pkg::job_t                 job,
    output logic                          mem_we,
    output logic [$clog2(FRAME_DEPTH)-1:0] mem_addr,
    output logic [7:0]                    mem_wdata,
    input  logic                          drain_done
);
    import sfr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int PW = $clog2(FRAME_DEPTH + 1);
    localparam int CW = (PW > 7) ? PW : 7;

    logic [PW-1:0] wpos_reg, wpos_next;
    logic [7:0]    xor_reg, xor_next;
    logic          prev_cr_reg, prev_cr_next;
    logic          active_reg, active_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    counters_t     cnt_reg, cnt_next;
    logic [15:0]   timeout_reg;
    logic [6:0]    copy_reg;
    logic          busy_reg, busy_next;

    logic          accept;
    logic [PW-1:0] pos1;
    logic [CW-1:0] pos1_w;
    logic [7:0]    xor_new;
    logic [6:0]    copy_lim;
    logic [6:0]    run_cap;
    logic [6:0]    run_len;
    logic [15:0]   elapsed_inc;
    logic [15:0]   timeout_lim;
    logic          frame_end;

    // A drain of a good frame reads the frame store, so nothing is taken
    // until it has finished.
    assign req_ready = !busy_reg && job_ready;
    assign cfg_ready = 1'b1;
    assign accept    = req_valid && req_ready;

    assign pos1        = wpos_reg + PW'(1);
    assign pos1_w      = CW'(pos1);
    assign xor_new     = (wpos_reg == '0) ? 8'h00 : (xor_reg ^ req.rx_byte);
    assign copy_lim    = (copy_reg == 7'd0) ? 7'd1 : copy_reg;
    assign run_cap     = (copy_lim > MAX_RUN) ? MAX_RUN : copy_lim;
    assign run_len     = (pos1_w < CW'(run_cap)) ? pos1_w[6:0] : run_cap;
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign timeout_lim = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign frame_end   = (pos1 >= PW'(2)) && prev_cr_reg && (req.rx_byte == LF_BYTE);

    assign mem_addr  = wpos_reg[AW-1:0];
    assign mem_wdata = req.rx_byte;

    always_comb
    begin
        wpos_next         = wpos_reg;
        xor_next          = xor_reg;
        prev_cr_next      = prev_cr_reg;
        active_next       = active_reg;
        elapsed_next      = elapsed_reg;
        cnt_next          = cnt_reg;
        busy_next         = busy_reg && !drain_done;
        job_valid         = 1'b0;
        job.status        = ST_GOOD;
        job.frame_length  = pos1_w[6:0];
        job.run_length    = 7'd1;
        mem_we            = 1'b0;
        if (accept)
        begin
            case (req.req_type)
                REQ_START:
                begin
                    cnt_next.attempts = cnt_reg.attempts + 32'd1;
                    active_next       = 1'b1;
                    wpos_next         = '0;
                    xor_next          = 8'h00;
                    elapsed_next      = 16'd0;
                end
                REQ_BYTE:
                begin
                    if (active_reg && !(wpos_reg == '0 && req.rx_byte != START_BYTE))
                    begin
                        mem_we       = 1'b1;
                        xor_next     = xor_new;
                        prev_cr_next = (req.rx_byte == CR_BYTE);
                        if (frame_end && pos1_w < CW'(MIN_FRAME))
                        begin
                            cnt_next.parse_error = cnt_reg.parse_error + 32'd1;
                            job_valid  = 1'b1;
                            job.status = ST_PARSE;
                            wpos_next  = '0;
                        end
                        else if (frame_end && (xor_new ^ CR_BYTE ^ LF_BYTE) != 8'h00)
                        begin
                            cnt_next.checksum_error = cnt_reg.checksum_error + 32'd1;
                            job_valid  = 1'b1;
                            job.status = ST_CHECKSUM;
                            wpos_next  = '0;
                        end
                        else if (frame_end)
                        begin
                            cnt_next.received = cnt_reg.received + 32'd1;
                            job_valid      = 1'b1;
                            job.status     = ST_GOOD;
                            job.run_length = run_len;
                            active_next    = 1'b0;
                            wpos_next      = '0;
                            xor_next       = 8'h00;
                            busy_next      = 1'b1;
                        end
                        else
                        begin
                            // Overflow starts the buffer over empty.
                            wpos_next = (pos1 >= PW'(FRAME_DEPTH)) ? '0 : pos1;
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (active_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_lim)
                        begin
                            active_next      = 1'b0;
                            wpos_next        = '0;
                            xor_next         = 8'h00;
                            cnt_next.failed  = cnt_reg.failed + 32'd1;
                            cnt_next.timeout = cnt_reg.timeout + 32'd1;
                            job_valid        = 1'b1;
                            job.status       = ST_TIMEOUT;
                            job.frame_length = 7'd0;
                        end
                    end
                end
                default:
                begin
                    cnt_next = '0;
                end
            endcase
        end
        job.counters = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg    <= '0;
            xor_reg     <= 8'h00;
            prev_cr_reg <= 1'b0;
            active_reg  <= 1'b0;
            elapsed_reg <= 16'd0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            copy_reg    <= COPY_RESET;
        end
        else
        begin
            wpos_reg    <= wpos_next;
            xor_reg     <= xor_next;
            prev_cr_reg <= prev_cr_next;
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_COPY:    copy_reg    <= cfg_data[6:0];
                    default:     ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/sfr_queue.sv =====
module sfr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  sfr_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sfr_pkg::job_t pop_data
);
    import sfr_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

`ifndef SYNTH
    // The front end holds its requests off while the queue is full.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("job pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop after a pop");
`endif

endmodule

// ===== rtl/core/sfr_back.sv =====
module sfr_back #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           mem_we,
    input  logic [$clog2(FRAME_DEPTH)-1:0] mem_addr,
    input  logic [7:0]                     mem_wdata,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  sfr_pkg::job_t                  job,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output sfr_pkg::rsp_t                  rsp,
    output logic                           drain_done
);
    import sfr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int XW = (AW > 7) ? AW : 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_SHOW
    } state_t;

    state_t        state_reg;
    job_t          job_reg;
    logic [XW-1:0] idx_reg;
    logic [7:0]    store_mem [FRAME_DEPTH];
    logic [7:0]    rdata_reg;
    rsp_t          rsp_reg;
    logic          rsp_valid_reg;
    logic          done_reg;

    assign job_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign drain_done = done_reg;

    // Frame store: written by the front end, read one byte per fetch.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= store_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            idx_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        idx_reg   <= '0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    rsp_reg.status       <= job_reg.status;
                    rsp_reg.data_byte    <= (job_reg.status == ST_GOOD) ? rdata_reg : 8'h00;
                    rsp_reg.last         <= ((idx_reg + XW'(1)) == XW'(job_reg.run_length));
                    rsp_reg.frame_length <= job_reg.frame_length;
                    rsp_reg.attempts_count       <= job_reg.counters.attempts;
                    rsp_reg.received_count       <= job_reg.counters.received;
                    rsp_reg.failed_count         <= job_reg.counters.failed;
                    rsp_reg.checksum_error_count <= job_reg.counters.checksum_error;
                    rsp_reg.timeout_count        <= job_reg.counters.timeout;
                    rsp_reg.parse_error_count    <= job_reg.counters.parse_error;
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= S_SHOW;
                end
                S_SHOW:
                begin
                    if (rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        if (rsp_reg.last)
                        begin
                            done_reg  <= (job_reg.status == ST_GOOD);
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + XW'(1);
                            state_reg <= S_FETCH;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/serial_frame_receiver_with_stats.sv =====
// Serial frame receiver with event counters.
// Requests arrive on req (valid/ready): start a read attempt, a received byte,
// a one-millisecond tick, or a counter clear. Results leave on rsp
// (valid/ready); each carries a status, a data byte, a last flag, the frame
// length and a snapshot of all six event counters as they stood right after
// the request that caused it. Registers (timeout in ticks at index 0,
// max_copy_len at index 1) are written through the cfg channel, which is
// always ready.
// A request is classified in the cycle it is accepted. Up to two pending
// results wait in a job queue, so error and timeout results do not stall
// the request side unless both queue slots are taken.
// The first result passes the job queue and the drain side's fetch and load
// states before it is registered on rsp. Each result goes through fetch (from
// the registered frame store read port), load and present; no new request is
// accepted until the drain of a run of frame bytes is complete.
// At reset the attempt closes, counters clear, and the registers return to
// 200 ms and 32 bytes. The frame store needs no clearing pass.
// When the receiver holds rsp_ready low, the result stays on rsp unchanged
// and the queue fills; once it is full req_ready drops.
module serial_frame_receiver_with_stats #(
    parameter int FRAME_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sfr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sfr_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import sfr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);

    // Front end to queue.
    logic          push_valid;
    logic          push_ready;
    job_t          push_job;

    // Queue to drain side.
    logic          pop_valid;
    logic          pop_ready;
    job_t          pop_job;

    // Frame store write port, driven by the front end.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    // Pulses when the last byte of a good frame has been taken.
    logic          drain_done;

    sfr_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job_valid  (push_valid),
        .job_ready  (push_ready),
        .job        (push_job),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .drain_done (drain_done)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    sfr_back #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job        (pop_job),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .drain_done (drain_done)
    );

endmodule
